/* hdl/bnb_pkg.sv */
// ----------------------------------------------------------------------------
// Bernoulli naive Bayes package
// Shared item types, default sizes and input kind codes.
// ----------------------------------------------------------------------------
package bnb_pkg;

  localparam int DEF_NUM_FEATURES = 512;
  localparam int DEF_NUM_CLASSES  = 16;
  localparam int DEF_COUNT_WIDTH  = 16;
  localparam int DEF_FRAC_BITS    = 16;

  localparam int CFG_W          = 10;
  localparam int FIU_RESET      = 512;

  localparam logic [1:0] KIND_TRAIN    = 2'd0;
  localparam logic [1:0] KIND_CLASSIFY = 2'd1;
  localparam logic [1:0] KIND_CLEAR    = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  class_label;
    logic [2:0]  chunk_index;
    logic [63:0] feature_bits;
    logic        last_chunk;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         predicted_class;
    logic signed [31:0] best_score;
    logic               no_class;
  } out_item_t;

endpackage

/* hdl/bernoulli_naive_bayes.sv */
// ----------------------------------------------------------------------------
// Bernoulli naive Bayes engine
// Per-class feature counts in one memory, trained and scored by a sequencer.
// ----------------------------------------------------------------------------
// Train chunk: one count read-modify-write a cycle. Clear: one sweep of the memory.
// A classify chunk that is not last is stored. The last classify chunk scores every
// class: an untrained class is skipped, a trained one takes three logs and then one
// count read and one log per feature in use, one log2 at a time.
// After reset and after a clear, the count memory is swept to zero, all
// 2**(clog2(NUM_CLASSES) + max(clog2(NUM_FEATURES),7)) words (8192 by default).
module bernoulli_naive_bayes #(
  parameter int NUM_FEATURES = bnb_pkg::DEF_NUM_FEATURES,
  parameter int NUM_CLASSES  = bnb_pkg::DEF_NUM_CLASSES,
  parameter int COUNT_WIDTH  = bnb_pkg::DEF_COUNT_WIDTH,
  parameter int FRAC_BITS    = bnb_pkg::DEF_FRAC_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [bnb_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  bnb_pkg::in_item_t        in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output bnb_pkg::out_item_t       out_item_o
);

  import bnb_pkg::*;

  localparam int CLW = $clog2(NUM_CLASSES);
  localparam int FW  = ($clog2(NUM_FEATURES) > 7) ? $clog2(NUM_FEATURES) : 7;
  localparam int CXW = FW - 6;
  localparam int AW  = CLW + FW;
  localparam int XW  = COUNT_WIDTH + 1;
  localparam int LW  = 6 + FRAC_BITS;
  localparam int NFW = ($clog2(NUM_FEATURES + 1) > CFG_W) ? $clog2(NUM_FEATURES + 1) : CFG_W;
  localparam int NUM_CHUNKS = (NUM_FEATURES + 63) / 64;
  localparam int SW0 = LW + $clog2(NUM_FEATURES + 2) + 2;
  localparam int SW  = (SW0 > 33) ? SW0 : 33;
  localparam logic signed [SW-1:0] SAT_MIN = SW'(-(64'sd1 <<< 31));

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_TRAIN  = 12'b000000000100,
    S_CSTART = 12'b000000001000,
    S_LNC    = 12'b000000010000,
    S_LN     = 12'b000000100000,
    S_LDEN   = 12'b000001000000,
    S_FRD    = 12'b000010000000,
    S_FX     = 12'b000100000000,
    S_FLOG   = 12'b001000000000,
    S_CEND   = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0]       fiu_q;
  logic [COUNT_WIDTH-1:0] cnt_q [NUM_CLASSES];
  logic [COUNT_WIDTH-1:0] total_q;
  logic [63:0]            doc_q [2**CXW];
  logic [AW-1:0]          clr_q, clr_d;

  logic [CLW-1:0]   lab_q;
  logic [CXW-1:0]   chunk_q;
  logic             chunk_ok_q;
  logic [63:0]      bits_q;
  logic [6:0]       b_q, b_d;
  logic             wpend_q, wpend_d;
  logic [AW-1:0]    wa_q;

  logic [CLW-1:0]   c_q, c_d;
  logic [NFW-1:0]   t_q, t_d;
  logic [LW-1:0]    a_q, lden_q;
  logic signed [SW-1:0] s_q, best_q;
  logic [CLW-1:0]   bestc_q;
  logic             found_q;

  logic             out_valid_q;
  out_item_t        out_q;

  logic                   acc;
  logic                   lab_ok, chunk_ok;
  logic [CXW-1:0]         chunk_in;
  logic [NFW-1:0]         nf;
  logic [COUNT_WIDTH-1:0] nc, nct, rdata;
  logic                   present, fvalid;
  logic [AW-1:0]          raddr, train_addr, waddr;
  logic                   we;
  logic [COUNT_WIDTH-1:0] wdata;
  logic                   log_start, log_done;
  logic [XW-1:0]          log_x;
  logic [LW-1:0]          log_res;
  logic [SW-1:0]          res_ext, lden_ext, a_ext;
  logic                   out_free;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign acc         = in_valid_i && in_ready_o;
  assign lab_ok      = 32'(in_item_i.class_label) < NUM_CLASSES;
  assign chunk_ok    = 32'(in_item_i.chunk_index) < NUM_CHUNKS;
  assign chunk_in    = CXW'(in_item_i.chunk_index);
  assign nf = (NFW'(fiu_q) < NFW'(NUM_FEATURES)) ? NFW'(fiu_q) : NFW'(NUM_FEATURES);
  assign nc          = cnt_q[c_q];
  assign nct         = (rdata > nc) ? nc : rdata;
  assign present     = doc_q[t_q[FW-1:6]][t_q[5:0]];
  assign train_addr  = {lab_q, chunk_q, b_q[5:0]};
  assign fvalid      = chunk_ok_q && (32'({chunk_q, b_q[5:0]}) < NUM_FEATURES);
  assign res_ext     = SW'(log_res);
  assign lden_ext    = SW'(lden_q);
  assign a_ext       = SW'(a_q);
  assign out_free    = !out_valid_q || out_ready_i;

  // Training reads in one cycle and writes the incremented count in the next.
  assign raddr = (state_q == S_TRAIN) ? train_addr : {c_q, t_q[FW-1:0]};
  assign we    = (state_q == S_CLEAR) || ((state_q == S_TRAIN) && wpend_q);
  assign waddr = (state_q == S_CLEAR) ? clr_q : wa_q;
  assign wdata = (state_q == S_CLEAR) ? '0 :
                 ((&rdata) ? rdata : rdata + COUNT_WIDTH'(1));

  bnb_ram #(.AW(AW), .DW(COUNT_WIDTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bnb_log2 #(.XW(XW), .FRAC_BITS(FRAC_BITS)) u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .x_i     (log_x),
    .done_o  (log_done),
    .res_o   (log_res)
  );

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    b_d       = b_q;
    wpend_d   = 1'b0;
    c_d       = c_q;
    t_d       = t_q;
    log_start = 1'b0;
    log_x     = XW'(nc);
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          case (in_item_i.kind)
            KIND_TRAIN: begin
              if (lab_ok) begin
                b_d     = '0;
                state_d = S_TRAIN;
              end
            end
            KIND_CLASSIFY: begin
              if (in_item_i.last_chunk) begin
                c_d     = '0;
                state_d = S_CSTART;
              end
            end
            KIND_CLEAR: begin
              clr_d   = '0;
              state_d = S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      S_TRAIN: begin
        wpend_d = !b_q[6] && fvalid && bits_q[b_q[5:0]];
        b_d     = b_q + 7'd1;
        if (b_q[6]) begin
          state_d = S_IDLE;
        end
      end
      S_CSTART: begin
        if (nc == '0) begin
          state_d = S_CEND;
        end else begin
          log_start = 1'b1;
          log_x     = XW'(nc);
          state_d   = S_LNC;
        end
      end
      S_LNC: begin
        if (log_done) begin
          log_start = 1'b1;
          log_x     = XW'(total_q);
          state_d   = S_LN;
        end
      end
      S_LN: begin
        if (log_done) begin
          log_start = 1'b1;
          log_x     = XW'(nc) + XW'(2);
          state_d   = S_LDEN;
        end
      end
      S_LDEN: begin
        if (log_done) begin
          t_d     = '0;
          state_d = (nf == '0) ? S_CEND : S_FRD;
        end
      end
      S_FRD: state_d = S_FX;
      S_FX: begin
        log_start = 1'b1;
        log_x     = present ? XW'(nct) + XW'(1) : XW'(nc - nct) + XW'(1);
        state_d   = S_FLOG;
      end
      S_FLOG: begin
        if (log_done) begin
          t_d     = t_q + NFW'(1);
          state_d = (t_q + NFW'(1) == nf) ? S_CEND : S_FRD;
        end
      end
      S_CEND: begin
        c_d = c_q + CLW'(1);
        if (c_q == CLW'(NUM_CLASSES - 1)) begin
          state_d = S_OUT;
        end else begin
          state_d = S_CSTART;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      b_q         <= '0;
      wpend_q     <= 1'b0;
      c_q         <= '0;
      t_q         <= '0;
      fiu_q       <= CFG_W'(FIU_RESET);
      total_q     <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        cnt_q[i] <= '0;
      end
      for (int i = 0; i < 2**CXW; i++) begin
        doc_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      b_q     <= b_d;
      wpend_q <= wpend_d;
      c_q     <= c_d;
      t_q     <= t_d;
      if (cfg_valid_i) begin
        fiu_q <= cfg_data_i;
      end
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (acc) begin
        case (in_item_i.kind)
          KIND_TRAIN: begin
            if (lab_ok && in_item_i.last_chunk) begin
              if (!(&cnt_q[CLW'(in_item_i.class_label)])) begin
                cnt_q[CLW'(in_item_i.class_label)] <=
                  cnt_q[CLW'(in_item_i.class_label)] + COUNT_WIDTH'(1);
              end
              if (!(&total_q)) begin
                total_q <= total_q + COUNT_WIDTH'(1);
              end
            end
          end
          KIND_CLASSIFY: begin
            if (chunk_ok) begin
              doc_q[chunk_in] <= in_item_i.feature_bits;
            end
            found_q <= 1'b0;
          end
          KIND_CLEAR: begin
            total_q <= '0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
              cnt_q[i] <= '0;
            end
          end
          default: ;
        endcase
      end
      if ((state_q == S_CEND) && (nc != '0) && (!found_q || (s_q > best_q))) begin
        found_q <= 1'b1;
      end
      if ((state_q == S_OUT) && out_free) begin
        for (int i = 0; i < 2**CXW; i++) begin
          doc_q[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      lab_q      <= CLW'(in_item_i.class_label);
      chunk_q    <= chunk_in;
      chunk_ok_q <= chunk_ok;
      bits_q     <= in_item_i.feature_bits;
      best_q     <= '0;
      bestc_q    <= '0;
    end
    if (state_q == S_TRAIN) begin
      wa_q <= train_addr;
    end
    if ((state_q == S_LNC) && log_done) begin
      a_q <= log_res;
    end
    if ((state_q == S_LN) && log_done) begin
      s_q <= $signed(a_ext) - $signed(res_ext);
    end
    if ((state_q == S_LDEN) && log_done) begin
      lden_q <= log_res;
    end
    if ((state_q == S_FLOG) && log_done) begin
      s_q <= s_q + $signed(res_ext) - $signed(lden_ext);
    end
    if ((state_q == S_CEND) && (nc != '0) && (!found_q || (s_q > best_q))) begin
      best_q  <= s_q;
      bestc_q <= c_q;
    end
    if ((state_q == S_OUT) && out_free) begin
      out_q.predicted_class <= 4'(bestc_q);
      out_q.best_score      <= (best_q < SAT_MIN) ? 32'sh80000000 : best_q[31:0];
      out_q.no_class        <= !found_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* hdl/bnb_ram.sv */
// ----------------------------------------------------------------------------
// Count memory
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bnb_ram #(
  parameter int AW = 13,
  parameter int DW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/bnb_log2.sv */
// ----------------------------------------------------------------------------
// Fixed-point log2 unit
// Binary-search normalisation, then one squaring step per fraction bit.
// ----------------------------------------------------------------------------
module bnb_log2 #(
  parameter int XW        = 17,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [XW-1:0]         x_i,
  output logic                  done_o,
  output logic [6+FRAC_BITS-1:0] res_o
);

  localparam int FCW = $clog2(FRAC_BITS);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_NORM = 4'b0010,
    L_SQ   = 4'b0100,
    L_DONE = 4'b1000
  } lstate_e;

  lstate_e             state_q, state_d;
  logic [2:0]          k_q, k_d;
  logic [FCW-1:0]      i_q, i_d;
  logic [63:0]         y_q, y_d;
  logic [5:0]          p_q, p_d;
  logic [31:0]         m_q, m_d;
  logic [FRAC_BITS-1:0] frac_q, frac_d;
  logic                zero_q, zero_d;

  logic [6:0]  sh;
  logic [63:0] mask;
  logic [63:0] y_n;
  logic [5:0]  p_n;
  logic [63:0] prod;
  logic [32:0] mn;

  always_comb begin
    sh   = 7'd32 >> k_q;
    mask = ~({64{1'b1}} >> sh);
    if ((y_q & mask) == 64'd0) begin
      y_n = y_q << sh;
      p_n = p_q - sh[5:0];
    end else begin
      y_n = y_q;
      p_n = p_q;
    end
    prod = 64'(m_q) * 64'(m_q);
    mn   = prod[63:31];
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    i_d     = i_q;
    y_d     = y_q;
    p_d     = p_q;
    m_d     = m_q;
    frac_d  = frac_q;
    zero_d  = zero_q;
    unique case (state_q)
      L_NORM: begin
        y_d = y_n;
        p_d = p_n;
        k_d = k_q + 3'd1;
        if (k_q == 3'd5) begin
          m_d     = y_n[63:32];
          i_d     = '0;
          state_d = L_SQ;
        end
      end
      L_SQ: begin
        // A square of two or more gives a one bit and halves the mantissa.
        frac_d = {frac_q[FRAC_BITS-2:0], mn[32]};
        m_d    = mn[32] ? mn[32:1] : mn[31:0];
        i_d    = i_q + FCW'(1);
        if (i_q == FCW'(FRAC_BITS - 1)) begin
          state_d = L_DONE;
        end
      end
      L_DONE: state_d = L_IDLE;
      default: state_d = L_IDLE;
    endcase
    if (start_i) begin
      y_d     = 64'(x_i);
      p_d     = 6'd63;
      k_d     = '0;
      zero_d  = (x_i == '0);
      state_d = L_NORM;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      k_q     <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      i_q     <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q    <= y_d;
    p_q    <= p_d;
    m_q    <= m_d;
    frac_q <= frac_d;
    zero_q <= zero_d;
  end

  assign done_o = (state_q == L_DONE);
  assign res_o  = zero_q ? '0 : {p_q, frac_q};

endmodule

/* hdl/bnb_checker.sv */
// ----------------------------------------------------------------------------
// Bernoulli naive Bayes port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module bnb_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input bnb_pkg::out_item_t out_item_o
);

  import bnb_pkg::*;

  // A result item stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // With no trained class the item carries class zero and a zero score.
  a_no_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.no_class |->
      (out_item_o.predicted_class == 4'd0) && (out_item_o.best_score == 32'sd0))
    else $error("no_class item with nonzero payload");

  // Every score is a sum of logs of ratios at most one.
  a_score_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.best_score[31] || (out_item_o.best_score == 32'sd0))
    else $error("positive score");

  // Reset starts the count memory sweep, so the next cycle takes no item.
  a_reset_busy: assert property (@(posedge clk_i)
    !rst_ni |=> !in_ready_o)
    else $error("ready straight after reset");

endmodule

bind bernoulli_naive_bayes bnb_checker u_bnb_checker (.*);

/* tb/bernoulli_naive_bayes_tb.sv */
// ----------------------------------------------------------------------------
// Bernoulli naive Bayes engine testbench
// Drives training, classify, clear and unused items through the valid/ready
// ports. A scoreboard keeps its own copy of every count and predicts each
// classification result, which is checked field by field against the output.
// Runs several register settings and idle patterns on both sides.
// ----------------------------------------------------------------------------
module bernoulli_naive_bayes_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bnb_pkg::*;

  localparam int NFEAT      = DEF_NUM_FEATURES;
  localparam int NCLS       = DEF_NUM_CLASSES;
  localparam int NCHUNK     = (NFEAT + 63) / 64;
  localparam int CNT_MAX    = (1 << DEF_COUNT_WIDTH) - 1;
  localparam int FRAC       = DEF_FRAC_BITS;
  localparam int SETTLE     = 9000;
  localparam int STALL_LIMIT = 600000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;

  always #1 clk = ~clk;

  bernoulli_naive_bayes dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_item_o(out_item)
  );

  // Scoreboard copy of the engine state.
  int unsigned fiu_reg = FIU_RESET;
  int unsigned class_docs [NCLS];
  int unsigned feat_docs [NCLS][NFEAT];
  int unsigned all_docs;
  logic [63:0] doc_chunks [NCHUNK];

  in_item_t  pending_items [$];
  out_item_t expected_scores [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic in_taken = 1'b0;
  int quiet_cycles = 0;

  function automatic void add_item(in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic longint fixed_log2(longint unsigned x);
    int p;
    longint unsigned m, res;
    if (x == 0) return 0;
    p = 0;
    while (p < 63 && (x >> (p + 1)) != 0) p++;
    m = (p > 31) ? (x >> (p - 31)) : (x << (31 - p));
    res = longint'(p) << FRAC;
    for (int i = 0; i < FRAC; i++) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        res |= 64'd1 << (FRAC - 1 - i);
        m >>= 1;
      end
    end
    return longint'(res);
  endfunction

  function automatic int unsigned bump(int unsigned v);
    return (v < CNT_MAX) ? v + 1 : CNT_MAX;
  endfunction

  function automatic void clear_counts();
    all_docs = 0;
    foreach (class_docs[c]) class_docs[c] = 0;
    foreach (feat_docs[c, f]) feat_docs[c][f] = 0;
  endfunction

  // Updates the state for one accepted item and queues any score it produces.
  function automatic void absorb_item(in_item_t it);
    int unsigned nf, nc, nct;
    longint s, lden, best;
    logic found;
    int best_c;
    out_item_t r;
    case (it.kind)
      KIND_CLEAR: clear_counts();
      KIND_TRAIN: begin
        for (int b = 0; b < 64; b++)
          if (it.feature_bits[b])
            feat_docs[it.class_label][it.chunk_index * 64 + b] =
              bump(feat_docs[it.class_label][it.chunk_index * 64 + b]);
        if (it.last_chunk) begin
          class_docs[it.class_label] = bump(class_docs[it.class_label]);
          all_docs = bump(all_docs);
        end
      end
      KIND_CLASSIFY: begin
        doc_chunks[it.chunk_index] = it.feature_bits;
        if (it.last_chunk) begin
          nf = (fiu_reg < NFEAT) ? fiu_reg : NFEAT;
          found = 1'b0;
          best = 0;
          best_c = 0;
          for (int c = 0; c < NCLS; c++) begin
            nc = class_docs[c];
            if (nc == 0) continue;
            lden = fixed_log2(nc + 2);
            s = fixed_log2(nc) - fixed_log2(all_docs);
            for (int t = 0; t < nf; t++) begin
              nct = feat_docs[c][t];
              if (nct > nc) nct = nc;
              if (doc_chunks[t / 64][t % 64]) s += fixed_log2(nct + 1) - lden;
              else s += fixed_log2(nc - nct + 1) - lden;
            end
            if (!found || s > best) begin
              found = 1'b1;
              best = s;
              best_c = c;
            end
          end
          foreach (doc_chunks[i]) doc_chunks[i] = '0;
          if (best < -64'sd2147483648) best = -64'sd2147483648;
          r.predicted_class = best_c[3:0];
          r.best_score = found ? best[31:0] : '0;
          r.no_class = !found;
          expected_scores.insert(expected_scores.size(), r);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Driver: new items go out on the falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor, scoreboard and stall watchdog.
  always @(posedge clk) begin
    out_item_t want;
    logic moved;
    moved = 1'b0;
    in_taken <= in_valid && in_ready;
    if (in_valid && in_ready) begin
      absorb_item(in_item);
      moved = 1'b1;
    end
    if (out_valid && out_ready) begin
      moved = 1'b1;
      if (expected_scores.size() == 0) begin
        report_mismatch("unexpected result item", 1, 0);
      end else begin
        want = expected_scores.pop_front();
        if (out_item.predicted_class !== want.predicted_class)
          report_mismatch("predicted_class", out_item.predicted_class, want.predicted_class);
        if (out_item.best_score !== want.best_score)
          report_mismatch("best_score", out_item.best_score, want.best_score);
        if (out_item.no_class !== want.no_class)
          report_mismatch("no_class", out_item.no_class, want.no_class);
      end
    end
    if (cfg_valid && cfg_ready) moved = 1'b1;
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic [1:0] k, logic [3:0] lab, logic [2:0] ch,
                                         logic [63:0] bits, logic lst);
    in_item_t it;
    it.kind = k;
    it.class_label = lab;
    it.chunk_index = ch;
    it.feature_bits = bits;
    it.last_chunk = lst;
    return it;
  endfunction

  function automatic logic [63:0] random_bits();
    logic [63:0] a, b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(3))
      0: return a & b & {$urandom, $urandom};
      1: return a | b;
      2: return {$urandom_range(1) ? 32'hFFFF_FFFF : 32'h0, $urandom};
      default: return a;
    endcase
  endfunction

  // One document of nchunks chunks; chunks run in order from a random start,
  // with an occasional repeat.
  task automatic queue_doc(logic [1:0] k, logic [3:0] lab, int nchunks);
    int ch;
    ch = $urandom_range(NCHUNK - 1);
    for (int i = 0; i < nchunks; i++) begin
      add_item(make_item(k, lab, ch[2:0], random_bits(), i == nchunks - 1));
      if ($urandom_range(9) != 0) ch = (ch + 1) % NCHUNK;
    end
  endtask

  task automatic queue_random(int n);
    int start, r;
    start = pending_items.size();
    while (pending_items.size() - start < n) begin
      r = $urandom_range(99);
      if (r < 55) queue_doc(KIND_TRAIN, 4'($urandom), $urandom_range(1, NCHUNK));
      else if (r < 85) queue_doc(KIND_CLASSIFY, 4'($urandom), $urandom_range(1, 3));
      else if (r < 92)
        add_item(make_item(KIND_UNUSED, 4'($urandom), 3'($urandom),
                           {$urandom, $urandom}, 1'($urandom)));
      else
        add_item(make_item(KIND_TRAIN, 4'($urandom), 3'($urandom),
                           random_bits(), 1'b0));
    end
  endtask

  task automatic wait_idle();
    wait (pending_items.size() == 0 && !in_valid && expected_scores.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_fiu(logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    fiu_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    clear_counts();
    foreach (doc_chunks[i]) doc_chunks[i] = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset setting of the register.
    add_item(make_item(KIND_CLASSIFY, 4'd0, 3'd0, '1, 1'b1));
    add_item(make_item(KIND_UNUSED, 4'hF, 3'd7, '1, 1'b1));
    add_item(make_item(KIND_TRAIN, 4'd0, 3'd0, '1, 1'b0));
    add_item(make_item(KIND_TRAIN, 4'd0, 3'd7, '1, 1'b1));
    add_item(make_item(KIND_TRAIN, 4'd15, 3'd0, '0, 1'b1));
    add_item(make_item(KIND_TRAIN, 4'd15, 3'd3, {32{2'b10}}, 1'b1));
    // The same chunk twice pushes feature counts above the class count.
    add_item(make_item(KIND_TRAIN, 4'd0, 3'd1, {32{2'b01}}, 1'b0));
    add_item(make_item(KIND_TRAIN, 4'd0, 3'd1, {32{2'b01}}, 1'b0));
    add_item(make_item(KIND_TRAIN, 4'd0, 3'd1, '1, 1'b1));
    add_item(make_item(KIND_CLASSIFY, 4'd0, 3'd0, '1, 1'b0));
    add_item(make_item(KIND_CLASSIFY, 4'd0, 3'd7, '1, 1'b1));
    add_item(make_item(KIND_CLASSIFY, 4'd9, 3'd3, '0, 1'b1));
    // Two identically trained classes tie, and the lower index must win.
    add_item(make_item(KIND_CLEAR, 4'd0, 3'd0, '0, 1'b0));
    add_item(make_item(KIND_TRAIN, 4'd9, 3'd0, 64'hF0F0_1234_8765_00FF, 1'b1));
    add_item(make_item(KIND_TRAIN, 4'd3, 3'd0, 64'hF0F0_1234_8765_00FF, 1'b1));
    add_item(make_item(KIND_CLASSIFY, 4'd0, 3'd0, 64'h00F0_0004_0005_00F0, 1'b1));
    add_item(make_item(KIND_CLEAR, 4'hF, 3'd7, '1, 1'b1));
    add_item(make_item(KIND_CLASSIFY, 4'd0, 3'd2, '1, 1'b1));
    wait_idle();

    // Top of the register range, with only two classes so scoring stays short.
    write_fiu(10'h3FF);
    add_item(make_item(KIND_TRAIN, 4'd6, 3'd0, '1, 1'b1));
    queue_doc(KIND_TRAIN, 4'd11, NCHUNK);
    queue_doc(KIND_TRAIN, 4'd6, NCHUNK);
    queue_doc(KIND_CLASSIFY, 4'd0, NCHUNK);
    queue_doc(KIND_CLASSIFY, 4'd0, 2);
    wait_idle();

    write_fiu(10'd0);
    queue_random(200);
    wait_idle();

    send_idle_pct = 76;
    write_fiu(10'd7);
    queue_random(240);
    wait_idle();

    send_idle_pct = 0;
    recv_stall_pct = 76;
    write_fiu(10'd16);
    queue_random(240);
    wait_idle();

    send_idle_pct = 11;
    recv_stall_pct = 11;
    write_fiu(10'd1);
    queue_random(120);
    add_item(make_item(KIND_CLEAR, 4'($urandom), 3'($urandom), {$urandom, $urandom}, 1'b1));
    queue_random(110);

    wait (pending_items.size() == 0 && !in_valid && expected_scores.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
